### design/mtf_pkg.sv
package mtf_pkg;

	localparam int DEPTH     = 16;
	localparam int KEY_WIDTH = 64;
	localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W     = $clog2(DEPTH + 1);

	localparam logic [4:0] CLOCK_HOUR_RESET = 5'd14;
	localparam logic [5:0] MINUTES_PER_HOUR = 6'd60;
	localparam logic [4:0] HOURS_PER_DAY    = 5'd24;

	localparam logic FUNC_RECORD = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

	typedef struct packed {
		logic        func;
		logic [63:0] key;
		logic [3:0]  index;
	} in_item_t;

	typedef struct packed {
		logic        hit;
		logic [3:0]  hit_position;
		logic [4:0]  entry_count;
		logic        entry_valid;
		logic [63:0] entry_key;
		logic [4:0]  entry_hour;
		logic [5:0]  entry_minute;
	} out_item_t;

	typedef struct packed {
		logic [KEY_WIDTH-1:0] key;
		logic [4:0]           hour;
		logic [5:0]           minute;
	} entry_t;

	typedef struct packed {
		logic compare;
		logic commit;
	} cell_ctl_t;

endpackage

### design/mtf_cell.sv
module mtf_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mtf_pkg::cell_ctl_t                ctl,
	input  logic                              valid,
	input  logic [mtf_pkg::KEY_WIDTH-1:0]     cmp_key,
	input  mtf_pkg::entry_t                   prev,
	input  logic                              seen_in,
	output mtf_pkg::entry_t                   entry,
	output logic                              seen_out,
	output logic                              match
);
	import mtf_pkg::*;

	entry_t entry_q;
	logic   match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.compare) begin
			match_q <= valid && (entry_q.key == cmp_key);
		end
	end

	// A cell takes its left neighbor's entry unless the matching key lies before it.
	always_ff @(posedge clk) begin
		if (ctl.commit && !seen_in) begin
			entry_q <= prev;
		end
	end

	assign entry    = entry_q;
	assign match    = match_q;
	assign seen_out = seen_in | match_q;

endmodule

### design/move_to_front_history_list_unit.sv
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   in_data   (mtf_pkg::in_item_t)
// out      output     out_valid/out_stall out_data  (mtf_pkg::out_item_t)
//
// The transfer cycle of an item compares the key in all cells at once, and the busy state
// that follows moves entries one cell along the chain on a record and loads the output
// register. The busy state waits while a previous result is still held and out_stall is high.
// in_stall is high while an item is in the busy state.
// Reset empties the list and sets the clock to 14:00; list contents need no clearing.
module move_to_front_history_list_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mtf_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output mtf_pkg::out_item_t out_data
);
	import mtf_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_BUSY = 1'b1;

	logic                 state_q;
	logic                 func_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [3:0]           index_q;
	logic [CNT_W-1:0]     count_q;
	logic [4:0]           hour_q;
	logic [5:0]           minute_q;
	logic                 out_valid_q;
	out_item_t            out_q;

	logic                 accept;
	logic                 commit;
	logic                 commit_record;
	logic [4:0]           hour_nx;
	logic [5:0]           minute_nx;
	logic [CNT_W-1:0]     count_nx;
	logic                 any_hit;
	logic [IDX_W-1:0]     hit_pos;
	logic [IDX_W-1:0]     rd_idx;
	logic                 rd_ok;
	cell_ctl_t            ctl;
	entry_t               new_entry;
	entry_t               entries [DEPTH];
	entry_t               chain   [DEPTH];
	logic                 seen    [DEPTH+1];
	logic [DEPTH-1:0]     match_vec;

	assign in_stall      = (state_q == ST_BUSY);
	assign accept        = in_valid && !in_stall;
	assign commit        = (state_q == ST_BUSY) && (!out_valid_q || !out_stall);
	assign commit_record = commit && (func_q == FUNC_RECORD);

	always_comb begin
		minute_nx = minute_q + 6'd1;
		hour_nx   = hour_q;
		if (minute_nx >= MINUTES_PER_HOUR) begin
			minute_nx = 6'd0;
			hour_nx   = (hour_q + 5'd1 >= HOURS_PER_DAY) ? 5'd0 : hour_q + 5'd1;
		end
	end

	assign new_entry = '{key: key_q, hour: hour_nx, minute: minute_nx};
	assign ctl       = '{compare: accept, commit: commit_record};
	assign chain[0]  = new_entry;
	assign seen[0]   = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		mtf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.valid    (CNT_W'(i) < count_q),
			.cmp_key  (in_data.key[KEY_WIDTH-1:0]),
			.prev     (chain[i]),
			.seen_in  (seen[i]),
			.entry    (entries[i]),
			.seen_out (seen[i+1]),
			.match    (match_vec[i])
		);
		if (i < DEPTH - 1) begin : g_link
			assign chain[i+1] = entries[i];
		end
	end

	always_comb begin
		hit_pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (match_vec[i]) begin
				hit_pos = hit_pos | IDX_W'(i);
			end
		end
	end

	assign any_hit  = seen[DEPTH];
	assign count_nx = (!any_hit && count_q < CNT_W'(DEPTH)) ? count_q + CNT_W'(1) : count_q;
	assign rd_idx   = IDX_W'(index_q);
	assign rd_ok    = 32'(index_q) < 32'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			hour_q      <= CLOCK_HOUR_RESET;
			minute_q    <= 6'd0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (commit_record) begin
				count_q  <= count_nx;
				hour_q   <= hour_nx;
				minute_q <= minute_nx;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= in_data.func;
			key_q   <= in_data.key[KEY_WIDTH-1:0];
			index_q <= in_data.index;
		end
		if (commit) begin
			if (func_q == FUNC_RECORD) begin
				out_q.hit          <= any_hit;
				out_q.hit_position <= any_hit ? 4'(hit_pos) : 4'd0;
				out_q.entry_count  <= 5'(count_nx);
				out_q.entry_valid  <= 1'b1;
				out_q.entry_key    <= 64'(key_q);
				out_q.entry_hour   <= hour_nx;
				out_q.entry_minute <= minute_nx;
			end else begin
				out_q.hit          <= 1'b0;
				out_q.hit_position <= 4'd0;
				out_q.entry_count  <= 5'(count_q);
				out_q.entry_valid  <= rd_ok;
				out_q.entry_key    <= rd_ok ? 64'(entries[rd_idx].key) : 64'd0;
				out_q.entry_hour   <= rd_ok ? entries[rd_idx].hour : 5'd0;
				out_q.entry_minute <= rd_ok ? entries[rd_idx].minute : 6'd0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds list depth");

	a_unique_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BUSY |-> $onehot0(match_vec))
		else $error("key found in more than one cell");

	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		commit_record |=> count_q >= $past(count_q))
		else $error("entry count shrank on a record");

	a_clock_range: assert property (@(posedge clk) disable iff (!arst_n)
		minute_q < MINUTES_PER_HOUR && hour_q < HOURS_PER_DAY)
		else $error("stamp clock out of range");

	a_commit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> state_q == ST_IDLE && out_valid_q)
		else $error("result lost after commit");

endmodule

### tb/move_to_front_history_list_unit_tb.sv
`timescale 1ns / 1ps

module move_to_front_history_list_unit_tb;
	import mtf_pkg::*;

	typedef struct {
		in_item_t  stim;
		bit        typed;
		out_item_t want;
	} stim_row_t;

	localparam logic [63:0] KEY_ONES = '1;
	localparam out_item_t   NO_ENTRY = '0;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;

	logic [KEY_WIDTH-1:0] hist_key [DEPTH];
	logic [4:0]           hist_hour [DEPTH];
	logic [5:0]           hist_minute [DEPTH];
	int unsigned          hist_count = 0;
	logic [4:0]           now_hour = CLOCK_HOUR_RESET;
	logic [5:0]           now_minute = '0;

	out_item_t pending_results[$];
	stim_row_t dir_rows[$];
	bit        calm = 1'b0;
	int        mismatch_count = 0;
	int        results_checked = 0;
	int        record_count = 0;
	int        read_count = 0;
	int        hit_count = 0;
	int        drop_count = 0;
	int        day_wraps = 0;

	int          pool_sizes[8] = '{4, 18, 40, 17, 64, 16, 24, 2};
	int          read_pct[8] = '{20, 30, 25, 50, 15, 10, 30, 40};
	logic [63:0] key_pool[64];

	move_to_front_history_list_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic out_item_t advance_history(in_item_t it);
		out_item_t r;
		bit        found;
		int        pos;
		int        last;
		r = '0;
		found = 1'b0;
		pos = 0;
		if (it.func == FUNC_READ) begin
			r.entry_count = 5'(hist_count);
			if (it.index < hist_count) begin
				r.entry_valid = 1'b1;
				r.entry_key = 64'(hist_key[it.index]);
				r.entry_hour = hist_hour[it.index];
				r.entry_minute = hist_minute[it.index];
			end
			return r;
		end
		now_minute = now_minute + 6'd1;
		if (now_minute == MINUTES_PER_HOUR) begin
			now_minute = '0;
			if (now_hour == HOURS_PER_DAY - 5'd1) begin
				now_hour = '0;
				day_wraps++;
			end else begin
				now_hour = now_hour + 5'd1;
			end
		end
		for (int i = 0; i < int'(hist_count); i++) begin
			if (!found && hist_key[i] == it.key[KEY_WIDTH-1:0]) begin
				found = 1'b1;
				pos = i;
			end
		end
		if (found) begin
			last = pos;
			hit_count++;
		end else if (hist_count < DEPTH) begin
			last = int'(hist_count);
			hist_count++;
		end else begin
			last = DEPTH - 1;
			drop_count++;
		end
		for (int i = last; i > 0; i--) begin
			hist_key[i] = hist_key[i-1];
			hist_hour[i] = hist_hour[i-1];
			hist_minute[i] = hist_minute[i-1];
		end
		hist_key[0] = it.key[KEY_WIDTH-1:0];
		hist_hour[0] = now_hour;
		hist_minute[0] = now_minute;
		r.hit = found;
		r.hit_position = found ? 4'(pos) : 4'd0;
		r.entry_count = 5'(hist_count);
		r.entry_valid = 1'b1;
		r.entry_key = 64'(it.key[KEY_WIDTH-1:0]);
		r.entry_hour = now_hour;
		r.entry_minute = now_minute;
		return r;
	endfunction

	function automatic void check_result(out_item_t got);
		out_item_t want;
		bit        bad;
		results_checked++;
		if (pending_results.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("unexpected result at %0t: key=%h", $realtime, got.entry_key);
			return;
		end
		want = pending_results.pop_front();
		bad = (got.hit !== want.hit) || (got.hit_position !== want.hit_position) ||
			(got.entry_count !== want.entry_count) ||
			(got.entry_valid !== want.entry_valid) ||
			(got.entry_key !== want.entry_key) || (got.entry_hour !== want.entry_hour) ||
			(got.entry_minute !== want.entry_minute);
		if (bad) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("result %0d mismatch: expected hit=%0d pos=%0d cnt=%0d vld=%0d key=%h %0d:%0d",
					results_checked, want.hit, want.hit_position, want.entry_count,
					want.entry_valid, want.entry_key, want.entry_hour, want.entry_minute);
				$display("    got hit=%0d pos=%0d cnt=%0d vld=%0d key=%h %0d:%0d",
					got.hit, got.hit_position, got.entry_count, got.entry_valid,
					got.entry_key, got.entry_hour, got.entry_minute);
			end
		end
	endfunction

	task automatic send_item(in_item_t it, bit typed, out_item_t want);
		int        gap;
		out_item_t predicted;
		gap = calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		predicted = advance_history(it);
		pending_results.push_back(typed ? want : predicted);
		if (it.func == FUNC_READ)
			read_count++;
		else
			record_count++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	initial begin
		bit took;
		int hold;
		out_stall = 1'b0;
		hold = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			took = out_valid && !out_stall;
			if (took)
				check_result(out_data);
			if (took)
				hold = calm ? 0 : $urandom_range(0, 15);
			else if (hold > 0)
				hold--;
			out_stall <= (hold > 0);
		end
	end

	initial begin
		in_item_t it;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// An empty list, a full-width key and both ends of the index field come first.
		dir_rows.push_back(stim_row_t'{in_item_t'{FUNC_READ, 64'd0, 4'd0}, 1'b1, NO_ENTRY});
		dir_rows.push_back(stim_row_t'{in_item_t'{FUNC_READ, KEY_ONES, 4'd15}, 1'b1, NO_ENTRY});
		dir_rows.push_back(stim_row_t'{in_item_t'{FUNC_RECORD, 64'd0, 4'd15}, 1'b1,
			out_item_t'{1'b0, 4'd0, 5'd1, 1'b1, 64'd0, CLOCK_HOUR_RESET, 6'd1}});
		dir_rows.push_back(stim_row_t'{in_item_t'{FUNC_RECORD, KEY_ONES, 4'd0}, 1'b1,
			out_item_t'{1'b0, 4'd0, 5'd2, 1'b1, KEY_ONES, CLOCK_HOUR_RESET, 6'd2}});
		dir_rows.push_back(stim_row_t'{in_item_t'{FUNC_RECORD, 64'd0, 4'd0}, 1'b1,
			out_item_t'{1'b1, 4'd1, 5'd2, 1'b1, 64'd0, CLOCK_HOUR_RESET, 6'd3}});
		dir_rows.push_back(stim_row_t'{in_item_t'{FUNC_READ, 64'd0, 4'd0}, 1'b0, NO_ENTRY});
		dir_rows.push_back(stim_row_t'{in_item_t'{FUNC_READ, 64'd0, 4'd1}, 1'b0, NO_ENTRY});
		dir_rows.push_back(stim_row_t'{in_item_t'{FUNC_READ, 64'd0, 4'd2}, 1'b1,
			out_item_t'{1'b0, 4'd0, 5'd2, 1'b0, 64'd0, 5'd0, 6'd0}});
		dir_rows.push_back(stim_row_t'{in_item_t'{FUNC_READ, KEY_ONES, 4'd15}, 1'b1,
			out_item_t'{1'b0, 4'd0, 5'd2, 1'b0, 64'd0, 5'd0, 6'd0}});
		dir_rows.push_back(stim_row_t'{in_item_t'{FUNC_RECORD, KEY_ONES, 4'd0}, 1'b0, NO_ENTRY});
		dir_rows.push_back(stim_row_t'{in_item_t'{FUNC_RECORD, 64'h5555_5555_5555_5555, 4'd5},
			1'b0, NO_ENTRY});
		dir_rows.push_back(stim_row_t'{in_item_t'{FUNC_RECORD, 64'haaaa_aaaa_aaaa_aaaa, 4'd10},
			1'b0, NO_ENTRY});
		dir_rows.push_back(stim_row_t'{in_item_t'{FUNC_RECORD, 64'h8000_0000_0000_0000, 4'd0},
			1'b0, NO_ENTRY});
		dir_rows.push_back(stim_row_t'{in_item_t'{FUNC_RECORD, 64'd1, 4'd0}, 1'b0, NO_ENTRY});
		dir_rows.push_back(stim_row_t'{in_item_t'{FUNC_RECORD, 64'd0, 4'd0}, 1'b0, NO_ENTRY});
		dir_rows.push_back(stim_row_t'{in_item_t'{FUNC_READ, 64'h5555_5555_5555_5555, 4'd5},
			1'b0, NO_ENTRY});
		dir_rows.push_back(stim_row_t'{in_item_t'{FUNC_READ, 64'd0, 4'd6}, 1'b0, NO_ENTRY});
		dir_rows.push_back(stim_row_t'{in_item_t'{FUNC_RECORD, 64'd0, 4'd0}, 1'b0, NO_ENTRY});
		dir_rows.push_back(stim_row_t'{in_item_t'{FUNC_READ, 64'd0, 4'd0}, 1'b0, NO_ENTRY});
		foreach (dir_rows[r])
			send_item(dir_rows[r].stim, dir_rows[r].typed, dir_rows[r].want);
		drain_results();

		// Each phase draws keys from a pool of its own size, so that small pools give
		// frequent hits and large ones keep the list full and push old entries out.
		for (int ph = 0; ph < 8; ph++) begin
			calm = (ph == 2) || (ph == 5);
			foreach (key_pool[k])
				key_pool[k] = {$urandom(), $urandom()};
			repeat (200) begin
				it.func = ($urandom_range(0, 99) < read_pct[ph]) ? FUNC_READ : FUNC_RECORD;
				it.key = ($urandom_range(0, 9) == 0) ? {$urandom(), $urandom()} :
					key_pool[$urandom_range(0, pool_sizes[ph] - 1)];
				it.index = 4'($urandom_range(0, 15));
				send_item(it, 1'b0, NO_ENTRY);
			end
			drain_results();
		end

		calm = 1'b0;
		repeat (20) @(posedge clk);
		$display("Covered %0d records (%0d hits, %0d drops from a full list) and %0d reads.",
			record_count, hit_count, drop_count, read_count);
		$display("Stamp clock passed midnight %0d time(s); %0d results compared.",
			day_wraps, results_checked);
		if (mismatch_count == 0) begin
			$display("move_to_front_history_list_unit test passed");
		end else begin
			$display("move_to_front_history_list_unit test failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("move_to_front_history_list_unit test failed");
		$finish;
	end

endmodule
